// File: hdl/clock_frame_replacement_unit_defines.svh
// Assertion macros shared by the frame replacement unit.
`ifndef CLOCK_FRAME_REPLACEMENT_UNIT_DEFINES_SVH
`define CLOCK_FRAME_REPLACEMENT_UNIT_DEFINES_SVH

`ifndef SYNTH
// Checks that a condition holds at every clock edge outside reset.
`define CFRU_ASSERT(label, cond) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("frame replacement check failed");
// Checks that a consequence follows a trigger in the same cycle.
`define CFRU_ASSERT_IMP(label, trig, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |-> (cons)) \
    else $error("frame replacement check failed");
// Checks that a consequence follows a trigger in the next cycle.
`define CFRU_ASSERT_NXT(label, trig, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error("frame replacement check failed");
`else
`define CFRU_ASSERT(label, cond)
`define CFRU_ASSERT_IMP(label, trig, cons)
`define CFRU_ASSERT_NXT(label, trig, cons)
`endif

`endif

// File: hdl/cfru_pkg.sv
// Types, codes and constants of the frame replacement unit.
package cfru_pkg;

  localparam int unsigned FramesDefault = 64;
  localparam int unsigned FrameW        = 10;
  localparam int unsigned OwnerW        = 8;
  localparam int unsigned KindW         = 2;
  localparam int unsigned StatusW       = 2;
  localparam int unsigned ActionW       = 2;
  localparam int unsigned RemovedW      = 7;

  localparam logic [KindW-1:0] VM_FILE = 2'd0;
  localparam logic [KindW-1:0] VM_ANON = 2'd1;
  localparam logic [KindW-1:0] VM_BIN  = 2'd2;

  localparam logic [StatusW-1:0] ST_DONE     = 2'd0;
  localparam logic [StatusW-1:0] ST_NOTFOUND = 2'd1;
  localparam logic [StatusW-1:0] ST_FULL     = 2'd2;

  localparam logic [ActionW-1:0] ACT_DISCARD = 2'd0;
  localparam logic [ActionW-1:0] ACT_WRITE   = 2'd1;
  localparam logic [ActionW-1:0] ACT_SWAP    = 2'd2;

  typedef enum logic [2:0] {
    CMD_ADD    = 3'd0,
    CMD_TOUCH  = 3'd1,
    CMD_REMOVE = 3'd2,
    CMD_OWNER  = 3'd3,
    CMD_EVICT  = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_WALK,
    S_SCAN,
    S_DONE
  } state_e;

  typedef enum logic [1:0] {
    M_TOUCH,
    M_FRAME,
    M_OWNER,
    M_AT
  } mode_e;

  typedef struct packed {
    logic              dirty;
    logic              accessed;
    logic [KindW-1:0]  kind;
    logic [OwnerW-1:0] owner;
    logic [FrameW-1:0] frame;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

endpackage

// File: hdl/cfru_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cfru_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// File: hdl/clock_frame_replacement_unit.sv
// Clock (second-chance) frame replacement list: top level and sequencer.
//
// The unit keeps an ordered list of resident frames in one RAM and runs one
// command per input beat. The beat's tuser carries the command; the result
// beat carries status, victim frame, victim owner, evict action and the
// number of entries removed. All work goes through the single RAM read port
// at one entry per cycle: add writes the new entry at the end of the list,
// touch is one pass that marks the entry, remove and remove-owner are one pass
// that also compacts the list, and evict walks the list to a victim and then
// runs a compaction pass from the victim. The input is not ready while
// a command is being worked; a finished result sits in the output register,
// so the next command is accepted while that result waits to be taken.
`include "clock_frame_replacement_unit_defines.svh"

module clock_frame_replacement_unit
  import cfru_pkg::*;
#(
  parameter int unsigned FRAMES = FramesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // tdata: frame_number[9:0], owner[17:10], page_kind[19:18], is_write[20], zero pad.
  input  logic [23:0] s_axis_tdata_i,
  // tuser: cmd[2:0].
  input  logic [2:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // tdata: status[1:0], victim_frame[11:2], victim_owner[19:12], action[21:20],
  // removed_count[28:22], zero pad.
  output logic [31:0] m_axis_tdata_o
);

  localparam int unsigned IW = $clog2(FRAMES);
  localparam int unsigned CW = $clog2(FRAMES + 1);

  state_e              state_q, state_d;
  logic [2:0]          cmd_q, cmd_d;
  logic [FrameW-1:0]   frame_q, frame_d;
  logic [OwnerW-1:0]   owner_q, owner_d;
  logic [KindW-1:0]    kind_q, kind_d;
  logic                wr_q, wr_d;
  logic [CW-1:0]       count_q, count_d;
  logic                clk_valid_q, clk_valid_d;
  logic [IW-1:0]       clk_idx_q, clk_idx_d;
  logic [CW-1:0]       ra_q, ra_d;
  logic [IW-1:0]       rp_q, rp_d;
  logic                pv_q, pv_d;
  logic [CW-1:0]       w_q, w_d;
  logic [CW-1:0]       n0_q, n0_d;
  logic [IW-1:0]       pos_q, pos_d;
  logic                found_q, found_d;
  mode_e               mode_q, mode_d;
  logic [CW-1:0]       removed_q, removed_d;
  logic [StatusW-1:0]  status_q, status_d;
  logic [FrameW-1:0]   vframe_q, vframe_d;
  logic [OwnerW-1:0]   vowner_q, vowner_d;
  logic [ActionW-1:0]  action_q, action_d;
  logic                m_valid_q, m_valid_d;
  logic [31:0]         m_data_q, m_data_d;

  logic                ram_we;
  logic [IW-1:0]       ram_waddr, ram_raddr;
  entry_t              ram_wdata, ram_rdata;
  logic [EntryW-1:0]   ram_rbits;

  cfru_ram #(
    .Width(EntryW),
    .Depth(FRAMES)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rbits)
  );

  assign ram_rdata = entry_t'(ram_rbits);

  function automatic logic [IW-1:0] next_idx(logic [IW-1:0] x, logic [CW-1:0] n);
    next_idx = ((CW'(x) + CW'(1)) == n) ? '0 : IW'(CW'(x) + CW'(1));
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      clk_valid_q <= 1'b0;
      clk_idx_q   <= '0;
      m_valid_q   <= 1'b0;
      pv_q        <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      clk_valid_q <= clk_valid_d;
      clk_idx_q   <= clk_idx_d;
      m_valid_q   <= m_valid_d;
      pv_q        <= pv_d;
    end
  end

  // Payload and scan bookkeeping; every use is qualified by the state.
  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    frame_q   <= frame_d;
    owner_q   <= owner_d;
    kind_q    <= kind_d;
    wr_q      <= wr_d;
    ra_q      <= ra_d;
    rp_q      <= rp_d;
    w_q       <= w_d;
    n0_q      <= n0_d;
    pos_q     <= pos_d;
    found_q   <= found_d;
    mode_q    <= mode_d;
    removed_q <= removed_d;
    status_q  <= status_d;
    vframe_q  <= vframe_d;
    vowner_q  <= vowner_d;
    action_q  <= action_d;
    m_data_q  <= m_data_d;
  end

  always_comb begin
    logic          match;
    logic          drop;
    logic [CW-1:0] cnt_m1;
    logic [IW-1:0] idx_t;
    entry_t        e;

    state_d     = state_q;
    cmd_d       = cmd_q;
    frame_d     = frame_q;
    owner_d     = owner_q;
    kind_d      = kind_q;
    wr_d        = wr_q;
    count_d     = count_q;
    clk_valid_d = clk_valid_q;
    clk_idx_d   = clk_idx_q;
    ra_d        = ra_q;
    rp_d        = rp_q;
    pv_d        = 1'b0;
    w_d         = w_q;
    n0_d        = n0_q;
    pos_d       = pos_q;
    found_d     = found_q;
    mode_d      = mode_q;
    removed_d   = removed_q;
    status_d    = status_q;
    vframe_d    = vframe_q;
    vowner_d    = vowner_q;
    action_d    = action_q;
    m_valid_d   = m_valid_q;
    m_data_d    = m_data_q;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_wdata   = ram_rdata;
    ram_raddr   = ra_q[IW-1:0];
    match       = 1'b0;
    drop        = 1'b0;
    cnt_m1      = count_q - CW'(1);
    idx_t       = clk_idx_q;
    e           = ram_rdata;
    s_axis_tready_o = (state_q == S_IDLE);

    if (m_valid_q && m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          cmd_d   = s_axis_tuser_i;
          frame_d = s_axis_tdata_i[9:0];
          owner_d = s_axis_tdata_i[17:10];
          kind_d  = s_axis_tdata_i[19:18];
          wr_d    = s_axis_tdata_i[20];
          state_d = S_DECODE;
        end
      end

      S_DECODE: begin
        status_d  = ST_NOTFOUND;
        vframe_d  = '0;
        vowner_d  = '0;
        action_d  = ACT_DISCARD;
        removed_d = '0;
        found_d   = 1'b0;
        ra_d      = '0;
        w_d       = '0;
        n0_d      = count_q;
        state_d   = S_DONE;
        priority case (cmd_q)
          CMD_ADD: begin
            if (count_q >= CW'(FRAMES)) begin
              status_d = ST_FULL;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = count_q[IW-1:0];
              ram_wdata = '{dirty: 1'b0, accessed: 1'b0, kind: kind_q,
                            owner: owner_q, frame: frame_q};
              count_d   = count_q + CW'(1);
              status_d  = ST_DONE;
            end
          end
          CMD_TOUCH: begin
            mode_d  = M_TOUCH;
            state_d = S_SCAN;
          end
          CMD_REMOVE: begin
            mode_d  = M_FRAME;
            state_d = S_SCAN;
          end
          CMD_OWNER: begin
            mode_d  = M_OWNER;
            state_d = S_SCAN;
          end
          CMD_EVICT: begin
            if (count_q == '0) begin
              clk_valid_d = 1'b0;
              clk_idx_d   = '0;
            end else begin
              if (!clk_valid_q || (CW'(clk_idx_q) >= count_q)) begin
                clk_valid_d = 1'b1;
                clk_idx_d   = '0;
                ra_d        = '0;
              end else begin
                ra_d = CW'(clk_idx_q);
              end
              state_d = S_WALK;
            end
          end
          default: begin
          end
        endcase
      end

      // Second-chance walk; the read of the following entry is issued while
      // the current one is examined.
      S_WALK: begin
        pv_d = 1'b1;
        rp_d = ra_q[IW-1:0];
        ra_d = CW'(next_idx(ra_q[IW-1:0], count_q));
        if (pv_q) begin
          if (count_q == CW'(1)) begin
            clk_valid_d = 1'b0;
            clk_idx_d   = '0;
          end else begin
            clk_idx_d = next_idx(rp_q, count_q);
          end
          if (e.accessed) begin
            ram_we         = 1'b1;
            ram_waddr      = rp_q;
            ram_wdata      = e;
            ram_wdata.accessed = 1'b0;
            if (count_q == CW'(1)) begin
              pv_d    = 1'b0;
              state_d = S_DONE;
            end
          end else begin
            vframe_d = e.frame;
            vowner_d = e.owner;
            if (e.dirty) begin
              action_d = (e.kind == VM_FILE) ? ACT_WRITE : ACT_SWAP;
            end else begin
              action_d = (e.kind == VM_ANON) ? ACT_SWAP : ACT_DISCARD;
            end
            status_d = ST_DONE;
            pos_d    = rp_q;
            mode_d   = M_AT;
            ra_d     = CW'(rp_q);
            w_d      = CW'(rp_q);
            n0_d     = count_q;
            pv_d     = 1'b0;
            state_d  = S_SCAN;
          end
        end
      end

      // One pass over the list that matches and rewrites; the removing modes also compact it.
      S_SCAN: begin
        if (ra_q < n0_q) begin
          pv_d = 1'b1;
          rp_d = ra_q[IW-1:0];
          ra_d = ra_q + CW'(1);
        end
        if (pv_q) begin
          unique case (mode_q)
            M_TOUCH: match = !found_q && (e.frame == frame_q);
            M_FRAME: match = !found_q && (e.frame == frame_q);
            M_OWNER: match = (e.owner == owner_q);
            M_AT:    match = (rp_q == pos_q);
            default: match = 1'b0;
          endcase
          if (mode_q == M_TOUCH) begin
            if (match) begin
              found_d        = 1'b1;
              ram_we         = 1'b1;
              ram_waddr      = rp_q;
              ram_wdata      = e;
              ram_wdata.accessed = 1'b1;
              ram_wdata.dirty    = e.dirty | wr_q;
            end
          end else begin
            drop = match;
            if (drop) begin
              found_d   = 1'b1;
              removed_d = removed_q + CW'(1);
              count_d   = cnt_m1;
              if (clk_valid_q) begin
                if (cnt_m1 == '0) begin
                  clk_valid_d = 1'b0;
                  clk_idx_d   = '0;
                end else begin
                  if (w_q < CW'(clk_idx_q)) begin
                    idx_t = clk_idx_q - IW'(1);
                  end
                  if (CW'(idx_t) >= cnt_m1) begin
                    idx_t = '0;
                  end
                  clk_idx_d = idx_t;
                end
              end
            end else begin
              ram_we    = 1'b1;
              ram_waddr = w_q[IW-1:0];
              ram_wdata = e;
              w_d       = w_q + CW'(1);
            end
          end
        end
        if (!(ra_q < n0_q) && !pv_q) begin
          state_d = S_DONE;
          unique case (mode_q)
            M_TOUCH, M_FRAME: status_d = found_q ? ST_DONE : ST_NOTFOUND;
            M_OWNER:          status_d = (removed_q != '0) ? ST_DONE : ST_NOTFOUND;
            M_AT:             status_d = ST_DONE;
            default:          status_d = ST_NOTFOUND;
          endcase
        end
      end

      S_DONE: begin
        if (!m_valid_q || m_axis_tready_i) begin
          m_valid_d = 1'b1;
          m_data_d  = {3'b000, RemovedW'(removed_q), action_q, vowner_q, vframe_q,
                       status_q};
          state_d   = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  `CFRU_ASSERT(a_count_bound, count_q <= CW'(FRAMES))
  `CFRU_ASSERT_IMP(a_clock_in_list, (state_q == S_IDLE) && clk_valid_q, CW'(clk_idx_q) < count_q)
  `CFRU_ASSERT_NXT(a_busy_after_accept, s_axis_tvalid_i && s_axis_tready_o, !s_axis_tready_o)
  `CFRU_ASSERT_IMP(a_removed_done, m_valid_q && (m_data_q[28:22] != '0), m_data_q[1:0] == ST_DONE)

endmodule
